[design/assert_macros.svh]
// assertion macros shared by the checker files
// depends on nothing; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_CLK(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bdoq_pkg.sv]
// shared types, sizes and helpers of the broadcast drop-oldest queue hub
// depends on nothing
package bdoq_pkg;

   localparam int NUM_SUBSCRIBERS = 4;
   localparam int NUM_TOPICS      = 4;
   localparam int QUEUE_DEPTH     = 8;
   localparam int MESSAGE_WIDTH   = 64;

   localparam int SUB_IDX_W  = (NUM_SUBSCRIBERS > 1) ? $clog2(NUM_SUBSCRIBERS) : 1;
   localparam int PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_SUBSCRIBERS * QUEUE_DEPTH;
   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int TOPIC_W    = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_TOPIC_MAP = 1'b1;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic        op;
      logic [1:0]  topic;
      logic [1:0]  subscriber;
      logic [63:0] message_in;
   } req_type;

   typedef struct packed {
      logic        message_valid;
      logic [63:0] message_out;
      logic [3:0]  overwrite_mask;
      logic [3:0]  fill_level;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic                 latch_req;
      logic                 push_step;
      logic                 pop_step;
      logic                 load_rsp;
      logic [SUB_IDX_W-1:0] sub_idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;
   } status_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] store_addr(input logic [SUB_IDX_W-1:0] sub,
                                                    input logic [PTR_W-1:0] ptr);
      store_addr = ADDR_W'(sub) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
   endfunction

endpackage

[design/bdoq_ctrl.sv]
// controller of the queue hub: sequences pushes over the subscribers and pops
// depends on bdoq_pkg
module bdoq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   output bdoq_pkg::cmd_type     cmd,
   input  bdoq_pkg::status_type  status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PUSH = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [bdoq_pkg::SUB_IDX_W-1:0] sub_idx_ff, sub_idx_in;
   logic                           last_sub;

   assign req_ready = (state_ff == ST_IDLE);
   assign last_sub  = (sub_idx_ff == bdoq_pkg::SUB_IDX_W'(bdoq_pkg::NUM_SUBSCRIBERS - 1));

   always_comb begin
      state_in      = state_ff;
      sub_idx_in    = sub_idx_ff;
      cmd.latch_req = 1'b0;
      cmd.push_step = 1'b0;
      cmd.pop_step  = 1'b0;
      cmd.load_rsp  = 1'b0;
      cmd.sub_idx   = sub_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               sub_idx_in    = '0;
               state_in      = (req_op == bdoq_pkg::OP_POP) ? ST_POP : ST_PUSH;
            end
         end
         ST_PUSH: begin
            // one subscriber queue per cycle through the single store write port
            cmd.push_step = 1'b1;
            sub_idx_in    = sub_idx_ff + bdoq_pkg::SUB_IDX_W'(1);
            if (last_sub) begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            cmd.pop_step = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sub_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         sub_idx_ff <= sub_idx_in;
      end
   end

endmodule

[design/bdoq_datapath.sv]
// datapath of the queue hub: config registers, queue pointers, shared store, result register
// depends on bdoq_pkg
module bdoq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bdoq_pkg::req_type                    req_data,
   input  logic                                 csr_we,
   input  logic [bdoq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bdoq_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  bdoq_pkg::cmd_type                    cmd,
   output bdoq_pkg::status_type                 status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bdoq_pkg::rsp_type                    rsp_data
);

   localparam int NS = bdoq_pkg::NUM_SUBSCRIBERS;
   localparam int MW = bdoq_pkg::MESSAGE_WIDTH;

   logic [NS-1:0]                        enable_ff;
   logic [NS-1:0][bdoq_pkg::TOPIC_W-1:0] topic_map_ff;
   bdoq_pkg::req_type                    req_ff;

   logic [bdoq_pkg::PTR_W-1:0] rd_ptr_ff [NS];
   logic [bdoq_pkg::PTR_W-1:0] rd_ptr_in [NS];
   logic [bdoq_pkg::PTR_W-1:0] wr_ptr_ff [NS];
   logic [bdoq_pkg::PTR_W-1:0] wr_ptr_in [NS];
   logic [bdoq_pkg::CNT_W-1:0] cnt_ff    [NS];
   logic [bdoq_pkg::CNT_W-1:0] cnt_in    [NS];

   logic [MW-1:0] store_ff [bdoq_pkg::STORE_DEPTH];
   logic [MW-1:0] rd_data_ff;

   logic [NS-1:0]              mask_ff;
   logic                       valid_ff;
   logic [bdoq_pkg::CNT_W-1:0] fill_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   bdoq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [bdoq_pkg::SUB_IDX_W-1:0] push_sub, pop_sub;
   logic                           topic_ok, listens, full, do_write, pop_ok, do_pop;
   logic [bdoq_pkg::ADDR_W-1:0]    wr_addr, rd_addr;

   assign push_sub = cmd.sub_idx;
   assign pop_sub  = bdoq_pkg::SUB_IDX_W'(req_ff.subscriber);
   assign topic_ok = (int'(req_ff.topic) < bdoq_pkg::NUM_TOPICS);
   assign listens  = topic_ok && enable_ff[push_sub] && (topic_map_ff[push_sub] == req_ff.topic);
   assign full     = (cnt_ff[push_sub] == bdoq_pkg::CNT_W'(bdoq_pkg::QUEUE_DEPTH));
   assign do_write = cmd.push_step && listens;
   assign pop_ok   = (int'(req_ff.subscriber) < NS) && (cnt_ff[pop_sub] != '0);
   assign do_pop   = cmd.pop_step && pop_ok;
   assign wr_addr  = bdoq_pkg::store_addr(push_sub, wr_ptr_ff[push_sub]);
   assign rd_addr  = bdoq_pkg::store_addr(pop_sub, rd_ptr_ff[pop_sub]);

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         topic_map_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == bdoq_pkg::REG_ENABLE) begin
            enable_ff <= csr_wdata[NS-1:0];
         end
         if (csr_index == bdoq_pkg::REG_TOPIC_MAP) begin
            topic_map_ff <= csr_wdata[NS*bdoq_pkg::TOPIC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_write) begin
         wr_ptr_in[push_sub] = bdoq_pkg::next_ptr(wr_ptr_ff[push_sub]);
         // full queue: drop the oldest entry, count stays at depth
         if (full) begin
            rd_ptr_in[push_sub] = bdoq_pkg::next_ptr(rd_ptr_ff[push_sub]);
         end else begin
            cnt_in[push_sub] = cnt_ff[push_sub] + bdoq_pkg::CNT_W'(1);
         end
      end
      if (do_pop) begin
         rd_ptr_in[pop_sub] = bdoq_pkg::next_ptr(rd_ptr_ff[pop_sub]);
         cnt_in[pop_sub]    = cnt_ff[pop_sub] - bdoq_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            cnt_ff[i]    <= '0;
         end
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // shared message store, one write and one registered read per cycle
   // read data is held from the pop step until the result is loaded
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_ff[wr_addr] <= req_ff.message_in[MW-1:0];
      end
      if (cmd.pop_step) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
         fill_ff  <= '0;
      end else begin
         if (do_write && full) begin
            mask_ff[push_sub] <= 1'b1;
         end
         if (do_pop) begin
            valid_ff <= 1'b1;
            fill_ff  <= cnt_ff[pop_sub] - bdoq_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.message_valid   = valid_ff;
         rsp_data_in.message_out     = valid_ff ? 64'(rd_data_ff) : '0;
         rsp_data_in.overwrite_mask  = 4'(mask_ff);
         rsp_data_in.fill_level      = 4'(fill_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[design/broadcast_drop_oldest_queues.sv]
// push: item accepted, then one subscriber queue per cycle in ST_PUSH, then the result is loaded
// in ST_DONE once the result register is free; the next item is taken back in ST_IDLE
// pop: registered store read in ST_POP, then the result is loaded in ST_DONE the same way
// the push sequence is set by the single write port of the shared message store
// synchronous active-high reset empties every queue and clears enable and topic map
module broadcast_drop_oldest_queues (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bdoq_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bdoq_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [bdoq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bdoq_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bdoq_pkg::cmd_type    cmd;
   bdoq_pkg::status_type status;

   bdoq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.op),
      .cmd       (cmd),
      .status    (status)
   );

   bdoq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[design/bdoq_checker.sv]
// port-level checks of the queue hub and the bind that attaches them
// depends on bdoq_pkg, assert_macros.svh and broadcast_drop_oldest_queues
`include "assert_macros.svh"

module bdoq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input bdoq_pkg::rsp_type                rsp_data
);

   // a result waiting for the consumer holds still
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   `ASSERT_CLK(a_reset_no_rsp, clock, reset |=> !rsp_valid, "result shown right after reset")

   // pops never report overwrites
   `ASSERT_CLK_RST(a_pop_no_mask, clock, reset, rsp_valid && rsp_data.message_valid |-> rsp_data.overwrite_mask == '0, "overwrite mask on a pop result")

   // no message: data and fill level are zero
   `ASSERT_CLK_RST(a_empty_zero, clock, reset, rsp_valid && !rsp_data.message_valid |-> rsp_data.message_out == '0 && rsp_data.fill_level == '0, "data on a result without message")

   // one item at a time: busy right after an accept
   `ASSERT_CLK_RST(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "item accepted while busy")

endmodule

bind broadcast_drop_oldest_queues bdoq_checker u_bdoq_checker (.*);
